// File: rtl/core/bisection_tree_domain_key_defines.svh
// Assertion macros used by the checker file of the domain key block.
`ifndef BISECTION_TREE_DOMAIN_KEY_DEFINES_SVH
`define BISECTION_TREE_DOMAIN_KEY_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BTDK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define BTDK_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/btdk_pkg.sv
// Shared types and constants of the bisection tree domain key block.
package btdk_pkg;

  localparam int MAX_LEVELS = 6;
  localparam int NODE_SLOTS = 128;
  localparam int NODE_W     = $clog2(NODE_SLOTS);
  localparam int COORD_BITS = 32;
  localparam int AXIS_W     = 2;
  localparam int LVL_W      = 3;
  localparam int KEY_W      = 7;
  localparam int CMDQ_DEPTH = 2;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic signed [KEY_W-1:0] KEY_UNUSED = '1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SKIP,
    OP_WALK
  } btdk_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } btdk_state_e;

  typedef struct packed {
    logic [AXIS_W-1:0]            axis;
    logic signed [COORD_BITS-1:0] split;
    logic [NODE_W-1:0]            left;
    logic [NODE_W-1:0]            right;
  } btdk_node_t;

  typedef struct packed {
    btdk_op_e                     op;
    logic [NODE_W-1:0]            index;
    btdk_node_t                   node;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } btdk_cmd_t;

endpackage

// File: rtl/core/btdk_front.sv
// Front end: decode accepted items into commands and queue them for the walker.
module btdk_front import btdk_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind_i,
  input  logic [6:0]                   node_index_i,
  input  logic [AXIS_W-1:0]            node_axis_i,
  input  logic signed [COORD_BITS-1:0] node_split_i,
  input  logic [6:0]                   node_left_i,
  input  logic [6:0]                   node_right_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         in_use_i,
  output logic                         cmd_valid_o,
  output btdk_cmd_t                    cmd_o,
  input  logic                         cmd_pop_i
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  btdk_cmd_t            entry_q [CMDQ_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;
  btdk_cmd_t            cmd_new;
  logic                 do_push, do_pop;

  // Classify the item and clamp axis code three onto z.
  always_comb begin
    cmd_new            = '0;
    cmd_new.index      = node_index_i[NODE_W-1:0];
    cmd_new.node.axis  = (node_axis_i > AXIS_Z) ? AXIS_Z : node_axis_i;
    cmd_new.node.split = node_split_i;
    cmd_new.node.left  = node_left_i[NODE_W-1:0];
    cmd_new.node.right = node_right_i[NODE_W-1:0];
    cmd_new.pos_x      = pos_x_i;
    cmd_new.pos_y      = pos_y_i;
    cmd_new.pos_z      = pos_z_i;
    if (kind_i == KIND_LOAD) begin
      cmd_new.op = OP_LOAD;
    end else if (!in_use_i) begin
      cmd_new.op = OP_SKIP;
    end else begin
      cmd_new.op = OP_WALK;
    end
  end

  assign full        = (count_q == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: rtl/core/btdk_back.sv
// Back end: node table, level-by-level tree walk and result register.
module btdk_back import btdk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [LVL_W-1:0]        cfg_tree_levels_i,
  input  logic                    cmd_valid_i,
  input  btdk_cmd_t               cmd_i,
  output logic                    cmd_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [KEY_W-1:0] domain_key_o
);

  btdk_node_t                   node_mem [NODE_SLOTS];
  btdk_node_t                   rd_q;
  logic                         mem_we, mem_re;
  logic [NODE_W-1:0]            rd_addr;

  btdk_state_e                  state_q, state_d;
  logic [LVL_W-1:0]             tree_levels_q;
  logic [LVL_W-1:0]             levels_q, levels_d;
  logic [LVL_W-1:0]             lvl_q, lvl_d;
  logic [LVL_W-1:0]             lvl_next;
  logic [MAX_LEVELS-1:0]        key_q, key_d;
  logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [COORD_BITS-1:0] pos_sel;
  logic                         go_right;
  logic [LVL_W-1:0]             levels_sat;
  logic                         out_valid_q, out_valid_d;
  logic signed [KEY_W-1:0]      out_key_q, out_key_d;
  logic                         out_free;
  logic                         latch_pos;

  assign levels_sat = (tree_levels_q > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS)
                                                           : tree_levels_q;
  assign out_free   = !out_valid_q || pop;
  assign lvl_next   = lvl_q + 1'b1;

  always_comb begin
    case (rd_q.axis)
      AXIS_X:  pos_sel = pos_x_q;
      AXIS_Y:  pos_sel = pos_y_q;
      default: pos_sel = pos_z_q;
    endcase
  end

  assign go_right = (pos_sel > rd_q.split);

  always_comb begin
    state_d     = state_q;
    levels_d    = levels_q;
    lvl_d       = lvl_q;
    key_d       = key_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_addr     = '0;
    latch_pos   = 1'b0;
    out_valid_d = out_valid_q && !pop;
    out_key_d   = out_key_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_LOAD: begin
              mem_we    = 1'b1;
              cmd_pop_o = 1'b1;
            end
            OP_SKIP: begin
              if (out_free) begin
                out_valid_d = 1'b1;
                out_key_d   = KEY_UNUSED;
                cmd_pop_o   = 1'b1;
              end
            end
            OP_WALK: begin
              cmd_pop_o = 1'b1;
              latch_pos = 1'b1;
              levels_d  = levels_sat;
              lvl_d     = '0;
              key_d     = '0;
              if (levels_sat == '0) begin
                state_d = ST_DONE;
              end else begin
                mem_re  = 1'b1;
                rd_addr = '0;
                state_d = ST_WALK;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // Node data for this level sits in rd_q; steer to the child.
        key_d[lvl_q] = go_right;
        lvl_d        = lvl_next;
        if (lvl_next == levels_q) begin
          state_d = ST_DONE;
        end else begin
          mem_re  = 1'b1;
          rd_addr = go_right ? rd_q.right : rd_q.left;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_key_d   = KEY_W'(key_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tree_levels_q <= '0;
      out_valid_q   <= 1'b0;
      levels_q      <= '0;
      lvl_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      levels_q    <= levels_d;
      lvl_q       <= lvl_d;
      if (cfg_we_i) begin
        tree_levels_q <= cfg_tree_levels_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    out_key_q <= out_key_d;
    if (latch_pos) begin
      pos_x_q <= cmd_i.pos_x;
      pos_y_q <= cmd_i.pos_y;
      pos_z_q <= cmd_i.pos_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[cmd_i.index] <= cmd_i.node;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= node_mem[rd_addr];
    end
  end

  assign empty        = !out_valid_q;
  assign domain_key_o = out_key_q;

endmodule

// File: rtl/core/bisection_tree_domain_key.sv
// Top level of the bisection tree domain key block.
//
// Sorts particles into spatial domains with a bisection tree held in a
// 128-entry node table. Both sides look like a queue: push an item while
// full is low, pop a result while empty is low. A load item (kind 0)
// writes one node (axis, split, left child, right child) and gives no
// result; a classify item (kind 1) gives exactly one domain_key. An unused
// particle yields -1. Otherwise the walk starts at node 0 and runs for
// tree_levels levels (values above 6 act as 6); at level k a coordinate
// strictly greater than the node's split sets key bit k and goes right.
// Splits and positions are 32-bit signed fixed point. The front end takes
// one item per cycle while full is low into a two-entry command queue; the
// back end handles a load or an unused particle from its idle state and
// walks one level at a time, as each level waits for one registered read
// of the node table before the child address is known. The result register
// lets the next walk run while a key waits to be popped. tree_levels must
// be written by the user through cfg_we_i only while the block is idle;
// it is not enforced; nodes must be loaded before a walk reads them.
module bisection_tree_domain_key import btdk_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [LVL_W-1:0]             cfg_tree_levels_i,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind_i,
  input  logic [6:0]                   node_index_i,
  input  logic [AXIS_W-1:0]            node_axis_i,
  input  logic signed [COORD_BITS-1:0] node_split_i,
  input  logic [6:0]                   node_left_i,
  input  logic [6:0]                   node_right_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         in_use_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [KEY_W-1:0]      domain_key_o
);

  // Commands flow from the front queue to the walker.
  logic      cmd_valid;
  logic      cmd_pop;
  btdk_cmd_t cmd;

  btdk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .node_index_i (node_index_i),
    .node_axis_i  (node_axis_i),
    .node_split_i (node_split_i),
    .node_left_i  (node_left_i),
    .node_right_i (node_right_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .in_use_i     (in_use_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Walk the tree, hold the finished key until it is popped.
  btdk_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_tree_levels_i (cfg_tree_levels_i),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .domain_key_o      (domain_key_o)
  );

endmodule

// File: rtl/core/btdk_checker.sv
// Port-level checker for the bisection tree domain key block, with its bind.
`include "bisection_tree_domain_key_defines.svh"

module btdk_checker import btdk_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [LVL_W-1:0]             cfg_tree_levels_i,
  input logic                         empty,
  input logic                         pop,
  input logic signed [KEY_W-1:0]      domain_key_o
);

  logic [LVL_W-1:0] levels_q;
  logic [LVL_W-1:0] levels_sat;
  logic [KEY_W-1:0] key_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= '0;
    end else if (cfg_we_i) begin
      levels_q <= cfg_tree_levels_i;
    end
  end

  assign levels_sat = (levels_q > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : levels_q;
  assign key_shift  = $unsigned(domain_key_o) >> levels_sat;

  `BTDK_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(domain_key_o), "result item dropped or changed while waiting")
  `BTDK_ASSERT(a_key_range, clk_i, rst_ni,
    empty || (domain_key_o == KEY_UNUSED) || !domain_key_o[KEY_W-1], "domain key out of range")
  `BTDK_ASSERT(a_key_levels, clk_i, rst_ni,
    empty || (domain_key_o == KEY_UNUSED) || (key_shift == '0),
    "domain key sets bits beyond the configured levels")

endmodule

bind bisection_tree_domain_key btdk_checker u_btdk_checker (.*);
